// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion shorthands used by the checker file vvl_check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off during reset.
`define VVL_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define VVL_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/vvl_pkg.sv =====
// ----------------------------------------------------------------------------
// vvl_pkg
// Shared types, register indexes and constants of the velocity vector limiter.
// ----------------------------------------------------------------------------
package vvl_pkg;

  localparam int AXIS_WIDTH_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int OUT_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int SCALE_W        = 16;
  localparam int SPEED_W        = 16;
  localparam int RAD_W          = 64;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_CLAMP = 2'd1;
  localparam logic [1:0] MODE_NORM  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_LIMIT_X,
    REG_LIMIT_Y,
    REG_LIMIT_Z,
    REG_LIMIT_MODE,
    REG_SPEED_AFTER
  } vvl_reg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] axis_x;
    logic signed [FIELD_W-1:0] axis_y;
    logic signed [FIELD_W-1:0] axis_z;
    logic [FIELD_W-1:0]        speed_factor;
  } vvl_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
  } vvl_out_t;

  typedef struct packed {
    logic [2:0][SCALE_W-1:0] scale;
    logic [2:0][SCALE_W-1:0] limit;
    logic [1:0]              mode;
    logic                    after;
  } vvl_cfg_t;

  typedef struct packed {
    logic limited;
    logic after;
    logic clamp;
    logic norm;
  } vvl_flags_t;

  // Cycles from an accepted request to its result strobe.
  function automatic int vvl_latency(int axis_width);
    int vw;
    int qw;
    vw = axis_width + 17;
    qw = vw + ((axis_width <= 17) ? (17 - axis_width) : 0);
    return 4 + qw + 3 + (RAD_W / 2) + vw + 2;
  endfunction

endpackage

// ===== hdl/vvl_front.sv =====
// ----------------------------------------------------------------------------
// vvl_front
// Four stages: magnitude times scale, times speed, pre-limit value, clamp.
// ----------------------------------------------------------------------------
module vvl_front #(
  parameter int AXIS_WIDTH = vvl_pkg::AXIS_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  vvl_pkg::vvl_in_t                       req,
  input  vvl_pkg::vvl_cfg_t                      cfg,
  output logic                                   out_valid,
  output logic [2:0][AXIS_WIDTH+16:0]            v,
  output logic [2:0]                             neg,
  output logic [vvl_pkg::SPEED_W-1:0]            speed,
  output vvl_pkg::vvl_flags_t                    flags
);
  import vvl_pkg::*;

  localparam int VW = AXIS_WIDTH + 17;
  localparam int MW = AXIS_WIDTH + 16;
  localparam int PW = AXIS_WIDTH + 32;

  logic [2:0][AXIS_WIDTH-1:0] ax;
  logic [2:0][AXIS_WIDTH-1:0] mag;
  logic [2:0]                 neg_in;
  vvl_flags_t                 flags_in;

  logic [3:0]              vld;
  logic [2:0][MW-1:0]      m1, m2;
  logic [2:0][PW-1:0]      p2;
  logic [2:0][VW-1:0]      v3, v4;
  logic [2:0]              n1, n2, n3, n4;
  logic [SPEED_W-1:0]      sp1, sp2, sp3, sp4;
  vvl_flags_t              fl1, fl2, fl3, fl4;

  assign ax[0] = AXIS_WIDTH'($unsigned(req.axis_x));
  assign ax[1] = AXIS_WIDTH'($unsigned(req.axis_y));
  assign ax[2] = AXIS_WIDTH'($unsigned(req.axis_z));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = ax[i][AXIS_WIDTH-1];
      mag[i]    = neg_in[i] ? (AXIS_WIDTH'(0) - ax[i]) : ax[i];
    end
    flags_in.limited = ((cfg.mode == MODE_CLAMP) || (cfg.mode == MODE_NORM)) &&
                       (|cfg.limit);
    flags_in.after   = cfg.after;
    flags_in.clamp   = flags_in.limited && (cfg.mode == MODE_CLAMP);
    flags_in.norm    = flags_in.limited && (cfg.mode == MODE_NORM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1[i] <= MW'(mag[i]) * MW'(cfg.scale[i]);
      p2[i] <= PW'(m1[i]) * PW'(sp1);
      m2[i] <= m1[i];
      // Speed before limiting is folded in here with rounding to the scaled grid.
      if (fl2.limited && !fl2.after) begin
        v3[i] <= VW'(((PW+1)'(p2[i]) + (PW+1)'(1 << 14)) >> 15);
      end else begin
        v3[i] <= VW'(m2[i]);
      end
      if (fl3.clamp && (cfg.limit[i] != '0) &&
          (v3[i] > (VW'(cfg.limit[i]) << (AXIS_WIDTH - 1)))) begin
        v4[i] <= VW'(cfg.limit[i]) << (AXIS_WIDTH - 1);
      end else begin
        v4[i] <= v3[i];
      end
    end
    n1 <= neg_in;              n2 <= n1;  n3 <= n2;  n4 <= n3;
    sp1 <= req.speed_factor;   sp2 <= sp1; sp3 <= sp2; sp4 <= sp3;
    fl1 <= flags_in;           fl2 <= fl1; fl3 <= fl2; fl4 <= fl3;
  end

  assign out_valid = vld[3];
  assign v         = v4;
  assign neg       = n4;
  assign speed     = sp4;
  assign flags     = fl4;

endmodule

// ===== hdl/vvl_div.sv =====
// ----------------------------------------------------------------------------
// vvl_div
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// The caller guarantees that the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module vvl_div #(
  parameter int LANES  = 3,
  parameter int DW     = 16,
  parameter int QW     = 34,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [LANES-1:0][DW-1:0]      hi,
  input  logic [LANES-1:0][QW-1:0]      lo,
  input  logic [LANES-1:0][DW-1:0]      divisor,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [LANES-1:0][QW-1:0]      quot,
  output logic [SIDE_W-1:0]             out_side
);

  logic [QW:1]                   vld_q;
  logic [LANES-1:0][DW-1:0]      rem_q [1:QW];
  logic [LANES-1:0][QW-1:0]      num_q [1:QW];
  logic [LANES-1:0][QW-1:0]      qt_q  [1:QW];
  logic [LANES-1:0][DW-1:0]      dsr_q [1:QW];
  logic [SIDE_W-1:0]             sd_q  [1:QW];

  logic [LANES-1:0][DW-1:0]      cur_rem [QW];
  logic [LANES-1:0][QW-1:0]      cur_num [QW];
  logic [LANES-1:0][QW-1:0]      cur_qt  [QW];
  logic [LANES-1:0][DW-1:0]      cur_dsr [QW];
  logic [SIDE_W-1:0]             cur_sd  [QW];
  logic [LANES-1:0][DW-1:0]      rem_n   [QW];
  logic [LANES-1:0]              bit_n   [QW];

  always_comb begin
    logic [DW:0] trial;
    trial      = '0;
    cur_rem[0] = hi;
    cur_num[0] = lo;
    cur_qt[0]  = '0;
    cur_dsr[0] = divisor;
    cur_sd[0]  = in_side;
    for (int j = 1; j < QW; j++) begin
      cur_rem[j] = rem_q[j];
      cur_num[j] = num_q[j];
      cur_qt[j]  = qt_q[j];
      cur_dsr[j] = dsr_q[j];
      cur_sd[j]  = sd_q[j];
    end
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {cur_rem[j][l], cur_num[j][l][QW-1]};
        if (trial >= {1'b0, cur_dsr[j][l]}) begin
          rem_n[j][l] = DW'(trial - {1'b0, cur_dsr[j][l]});
          bit_n[j][l] = 1'b1;
        end else begin
          rem_n[j][l] = trial[DW-1:0];
          bit_n[j][l] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      rem_q[j+1] <= rem_n[j];
      dsr_q[j+1] <= cur_dsr[j];
      sd_q[j+1]  <= cur_sd[j];
      for (int l = 0; l < LANES; l++) begin
        num_q[j+1][l] <= cur_num[j][l] << 1;
        qt_q[j+1][l]  <= {cur_qt[j][l][QW-2:0], bit_n[j][l]};
      end
    end
  end

  assign out_valid = vld_q[QW];
  assign quot      = qt_q[QW];
  assign out_side  = sd_q[QW];

endmodule

// ===== hdl/vvl_mag.sv =====
// ----------------------------------------------------------------------------
// vvl_mag
// Squared magnitude of the limit ratios: range shift, squares, sum and the
// compare against one.
// ----------------------------------------------------------------------------
module vvl_mag #(
  parameter int QW     = 34,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [2:0][QW-1:0]                    q,
  input  logic [2:0]                            lzero,
  input  logic [SIDE_W-1:0]                     in_side,
  output logic                                  out_valid,
  output logic [vvl_pkg::RAD_W-1:0]             s,
  output logic                                  big,
  output logic [$clog2(QW-30)-1:0]              k,
  output logic [SIDE_W-1:0]                     out_side
);
  import vvl_pkg::*;

  localparam int KMAX = QW - 31;
  localparam int KW   = $clog2(KMAX + 1);
  localparam int TW   = 31;

  logic [2:0][QW-1:0]   qm;
  logic [QW-1:0]        q_or;
  logic [KW-1:0]        k_n;
  logic [2:0][TW-1:0]   t_n;

  logic [2:0]              vld;
  logic [2:0][TW-1:0]      t1;
  logic [2:0][2*TW-1:0]    sq2;
  logic [KW-1:0]           k1, k2, k3;
  logic [SIDE_W-1:0]       sd1, sd2, sd3;
  logic [RAD_W-1:0]        s3;
  logic                    big3;
  logic [RAD_W-1:0]        sum_n;
  logic [5:0]              thr_sh;

  // The shift is the least one that brings every ratio below two to the 31.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm[i] = lzero[i] ? '0 : q[i];
    end
    q_or = qm[0] | qm[1] | qm[2];
    k_n  = KW'(KMAX);
    for (int j = KMAX - 1; j >= 0; j--) begin
      if ((q_or >> j) < (QW'(1) << TW)) begin
        k_n = KW'(j);
      end
    end
    for (int i = 0; i < 3; i++) begin
      t_n[i] = TW'(qm[i] >> k_n);
    end
  end

  always_comb begin
    sum_n  = RAD_W'(sq2[0]) + RAD_W'(sq2[1]) + RAD_W'(sq2[2]);
    thr_sh = 6'(32 - 2 * int'(k2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    t1  <= t_n;
    k1  <= k_n;
    sd1 <= in_side;
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= (2*TW)'(t1[i]) * (2*TW)'(t1[i]);
    end
    k2   <= k1;
    sd2  <= sd1;
    s3   <= sum_n;
    big3 <= sum_n > (RAD_W'(1) << thr_sh);
    k3   <= k2;
    sd3  <= sd2;
  end

  assign out_valid = vld[2];
  assign s         = s3;
  assign big       = big3;
  assign k         = k3;
  assign out_side  = sd3;

endmodule

// ===== hdl/vvl_sqrt.sv =====
// ----------------------------------------------------------------------------
// vvl_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module vvl_sqrt #(
  parameter int NB     = vvl_pkg::RAD_W,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [NB-1:0]         rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [NB/2-1:0]       root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RW = NB / 2;

  logic [RW:1]           vld_q;
  logic [RW+1:0]         rem_q  [1:RW];
  logic [RW-1:0]         root_q [1:RW];
  logic [NB-1:0]         rad_q  [1:RW];
  logic [SIDE_W-1:0]     sd_q   [1:RW];

  logic [RW+1:0]         cur_rem  [RW];
  logic [RW-1:0]         cur_root [RW];
  logic [NB-1:0]         cur_rad  [RW];
  logic [SIDE_W-1:0]     cur_sd   [RW];
  logic [RW+1:0]         rem_n    [RW];
  logic [RW-1:0]         root_n   [RW];

  always_comb begin
    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    rem_sh      = '0;
    trial       = '0;
    cur_rem[0]  = '0;
    cur_root[0] = '0;
    cur_rad[0]  = rad;
    cur_sd[0]   = in_side;
    for (int j = 1; j < RW; j++) begin
      cur_rem[j]  = rem_q[j];
      cur_root[j] = root_q[j];
      cur_rad[j]  = rad_q[j];
      cur_sd[j]   = sd_q[j];
    end
    for (int j = 0; j < RW; j++) begin
      rem_sh = {cur_rem[j], cur_rad[j][NB-1:NB-2]};
      trial  = (RW+4)'({cur_root[j], 2'b01});
      if (rem_sh >= trial) begin
        rem_n[j]  = (RW+2)'(rem_sh - trial);
        root_n[j] = {cur_root[j][RW-2:0], 1'b1};
      end else begin
        rem_n[j]  = rem_sh[RW+1:0];
        root_n[j] = {cur_root[j][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RW-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < RW; j++) begin
      rem_q[j+1]  <= rem_n[j];
      root_q[j+1] <= root_n[j];
      rad_q[j+1]  <= cur_rad[j] << 2;
      sd_q[j+1]   <= cur_sd[j];
    end
  end

  assign out_valid = vld_q[RW];
  assign root      = root_q[RW];
  assign out_side  = sd_q[RW];

endmodule

// ===== hdl/vvl_back.sv =====
// ----------------------------------------------------------------------------
// vvl_back
// Applies the speed factor where still due, rounds to Q16.16 and saturates.
// ----------------------------------------------------------------------------
module vvl_back #(
  parameter int AXIS_WIDTH = vvl_pkg::AXIS_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [2:0][AXIS_WIDTH+16:0]           v,
  input  logic [2:0]                            neg,
  input  logic [vvl_pkg::SPEED_W-1:0]           speed,
  input  vvl_pkg::vvl_flags_t                   flags,
  output logic                                  out_valid,
  output vvl_pkg::vvl_out_t                     result
);
  import vvl_pkg::*;

  localparam int VW = AXIS_WIDTH + 17;
  localparam int WW = VW + 16;
  localparam int SH = AXIS_WIDTH + 6;

  logic [1:0]              vld;
  logic [2:0][WW-1:0]      w1;
  logic [2:0]              n1;
  logic [2:0][OUT_W-1:0]   o_n;
  vvl_out_t                res_q;

  always_comb begin
    logic [WW:0] rnd;
    logic [WW:0] mag;
    logic [OUT_W-1:0] sat;
    rnd = '0;
    mag = '0;
    sat = '0;
    for (int i = 0; i < 3; i++) begin
      rnd = (WW+1)'(w1[i]) + ((WW+1)'(1) << (SH - 1));
      mag = rnd >> SH;
      if (n1[i]) begin
        sat    = (mag > (WW+1)'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : mag[OUT_W-1:0];
        o_n[i] = OUT_W'(0) - sat;
      end else begin
        sat    = (mag > (WW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[OUT_W-1:0];
        o_n[i] = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (!flags.limited || flags.after) begin
        w1[i] <= WW'(v[i]) * WW'(speed);
      end else begin
        w1[i] <= WW'(v[i]) << 15;
      end
    end
    n1          <= neg;
    res_q.out_x <= o_n[0];
    res_q.out_y <= o_n[1];
    res_q.out_z <= o_n[2];
  end

  assign out_valid = vld[1];
  assign result    = res_q;

endmodule

// ===== hdl/velocity_vector_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// velocity_vector_limiter_unit
// Three-axis velocity command scaler and limiter, fully pipelined.
// ----------------------------------------------------------------------------
// A request (three signed axis values and a speed factor on req) is taken at
// every rising edge with start high and busy low. busy is high only while rst
// is applied, so one request can be given in every cycle.
// Each request produces exactly one result on result, marked by result_valid
// for a single cycle. A request passes the front stages, the ratio divider,
// the magnitude unit, the square root unit, the final divider and the back
// stages; the dividers and the square root each give one bit per stage.
// Throughput is one request per cycle in every mode. Ratio and final quotients
// are QW and VW bits; VW = AXIS_WIDTH + 17, QW = VW + max(0, 17 - AXIS_WIDTH).
// Registers are written through cfg_we, cfg_index and cfg_data; every index
// names one. The user must write them only while no request is in flight;
// the block does not enforce this. A synchronous reset restores the register
// defaults and empties the pipeline, dropping results of requests in flight.
// The receiver cannot hold results off; nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module velocity_vector_limiter_unit #(
  parameter int AXIS_WIDTH = vvl_pkg::AXIS_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  vvl_pkg::vvl_in_t                 req,
  input  logic                             cfg_we,
  input  logic [vvl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vvl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output vvl_pkg::vvl_out_t                result,
  output logic                             result_valid
);
  import vvl_pkg::*;

  localparam int VW   = AXIS_WIDTH + 17;
  localparam int SHL  = (AXIS_WIDTH <= 17) ? (17 - AXIS_WIDTH) : 0;
  localparam int SHR  = (AXIS_WIDTH > 17) ? (AXIS_WIDTH - 17) : 0;
  localparam int QW   = VW + SHL;
  localparam int DVW  = SCALE_W + SHR;
  localparam int KW   = $clog2(QW - 30);
  localparam int RW   = RAD_W / 2;

  typedef struct packed {
    logic [2:0][VW-1:0] v;
    logic [2:0]         neg;
    logic [SPEED_W-1:0] speed;
    vvl_flags_t         flags;
    logic [2:0]         lzero;
  } ctx_t;

  typedef struct packed {
    ctx_t          ctx;
    logic          big;
    logic [KW-1:0] k;
  } ctx2_t;

  vvl_cfg_t cfg;

  logic                 f_valid;
  logic [2:0][VW-1:0]   f_v;
  logic [2:0]           f_neg;
  logic [SPEED_W-1:0]   f_speed;
  vvl_flags_t           f_flags;
  ctx_t                 f_ctx;

  logic [2:0][DVW-1:0]  qd_divisor;
  logic [2:0][QW-1:0]   qd_lo;
  logic                 qd_valid;
  logic [2:0][QW-1:0]   qd_q;
  logic [$bits(ctx_t)-1:0] qd_side;
  ctx_t                 qd_ctx;

  logic                 mg_valid;
  logic [RAD_W-1:0]     mg_s;
  logic                 mg_big;
  logic [KW-1:0]        mg_k;
  logic [$bits(ctx_t)-1:0] mg_side;
  ctx2_t                mg_ctx2;

  logic                 sq_valid;
  logic [RW-1:0]        sq_root;
  logic [$bits(ctx2_t)-1:0] sq_side;
  ctx2_t                sq_ctx2;

  logic [2:0][RW-1:0]   dv_hi;
  logic [2:0][VW-1:0]   dv_lo;
  logic [2:0][RW-1:0]   dv_divisor;
  logic                 dv_valid;
  logic [2:0][VW-1:0]   dv_q;
  logic [$bits(ctx2_t)-1:0] dv_side;
  ctx2_t                dv_ctx2;
  logic [2:0][VW-1:0]   v_sel;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale <= {SCALE_RST, SCALE_RST, SCALE_RST};
      cfg.limit <= '0;
      cfg.mode  <= MODE_OFF;
      cfg.after <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_X:     cfg.scale[0] <= cfg_data;
        REG_SCALE_Y:     cfg.scale[1] <= cfg_data;
        REG_SCALE_Z:     cfg.scale[2] <= cfg_data;
        REG_LIMIT_X:     cfg.limit[0] <= cfg_data;
        REG_LIMIT_Y:     cfg.limit[1] <= cfg_data;
        REG_LIMIT_Z:     cfg.limit[2] <= cfg_data;
        REG_LIMIT_MODE:  cfg.mode     <= cfg_data[1:0];
        REG_SPEED_AFTER: cfg.after    <= cfg_data[0];
      endcase
    end
  end

  vvl_front #(.AXIS_WIDTH(AXIS_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .req       (req),
    .cfg       (cfg),
    .out_valid (f_valid),
    .v         (f_v),
    .neg       (f_neg),
    .speed     (f_speed),
    .flags     (f_flags)
  );

  always_comb begin
    f_ctx.v     = f_v;
    f_ctx.neg   = f_neg;
    f_ctx.speed = f_speed;
    f_ctx.flags = f_flags;
    for (int i = 0; i < 3; i++) begin
      f_ctx.lzero[i] = (cfg.limit[i] == '0);
      qd_lo[i]       = QW'(f_v[i]) << SHL;
      qd_divisor[i]  = DVW'(cfg.limit[i]) << SHR;
    end
  end

  // Ratio of each axis to its limit, 16 fraction bits.
  vvl_div #(.LANES(3), .DW(DVW), .QW(QW), .SIDE_W($bits(ctx_t))) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .hi        ('0),
    .lo        (qd_lo),
    .divisor   (qd_divisor),
    .in_side   (f_ctx),
    .out_valid (qd_valid),
    .quot      (qd_q),
    .out_side  (qd_side)
  );

  assign qd_ctx = qd_side;

  vvl_mag #(.QW(QW), .SIDE_W($bits(ctx_t))) u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qd_valid),
    .q         (qd_q),
    .lzero     (qd_ctx.lzero),
    .in_side   (qd_side),
    .out_valid (mg_valid),
    .s         (mg_s),
    .big       (mg_big),
    .k         (mg_k),
    .out_side  (mg_side)
  );

  always_comb begin
    mg_ctx2.ctx = mg_side;
    mg_ctx2.big = mg_big;
    mg_ctx2.k   = mg_k;
  end

  vvl_sqrt #(.NB(RAD_W), .SIDE_W($bits(ctx2_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mg_valid),
    .rad       (mg_s),
    .in_side   (mg_ctx2),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  assign sq_ctx2 = sq_side;

  // Quotient stays below 2^VW whenever the magnitude exceeds one.
  always_comb begin
    logic [VW+15:0] full;
    full = '0;
    for (int i = 0; i < 3; i++) begin
      full          = (VW+16)'(sq_ctx2.ctx.v[i]) << (16 - int'(sq_ctx2.k));
      dv_hi[i]      = RW'(full[VW+15:VW]);
      dv_lo[i]      = full[VW-1:0];
      dv_divisor[i] = sq_root;
    end
  end

  vvl_div #(.LANES(3), .DW(RW), .QW(VW), .SIDE_W($bits(ctx2_t))) u_norm_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .hi        (dv_hi),
    .lo        (dv_lo),
    .divisor   (dv_divisor),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .quot      (dv_q),
    .out_side  (dv_side)
  );

  assign dv_ctx2 = dv_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_sel[i] = (dv_ctx2.ctx.flags.norm && dv_ctx2.big) ? dv_q[i] : dv_ctx2.ctx.v[i];
    end
  end

  vvl_back #(.AXIS_WIDTH(AXIS_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .v         (v_sel),
    .neg       (dv_ctx2.ctx.neg),
    .speed     (dv_ctx2.ctx.speed),
    .flags     (dv_ctx2.ctx.flags),
    .out_valid (result_valid),
    .result    (result)
  );

endmodule

// ===== hdl/vvl_check.sv =====
// ----------------------------------------------------------------------------
// vvl_check
// Port-level checks of the limiter: empty after reset, one result per request
// at the fixed latency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vvl_check #(
  parameter int AXIS_WIDTH = vvl_pkg::AXIS_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);
  import vvl_pkg::*;

  localparam int LAT = vvl_latency(AXIS_WIDTH);

  // The pipeline holds nothing in the cycle after reset.
  `VVL_ASSERT(a_empty_after_reset, clk, $past(rst) |-> !result_valid, "result after reset")

  // Every result belongs to a request taken earlier, offset as vvl_latency gives.
  `VVL_ASSERT_RST(a_no_spurious, clk, rst, result_valid |-> $past(start && !busy, LAT), "result without request")

  // Every request taken gives its result later, offset as vvl_latency gives.
  `VVL_ASSERT_RST(a_no_loss, clk, rst, (start && !busy) |-> ##LAT result_valid, "request lost")

endmodule

bind velocity_vector_limiter_unit vvl_check #(.AXIS_WIDTH(AXIS_WIDTH)) u_vvl_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid)
);
